FILE: hdl/spectral_peak_grain_picker_top_assert.svh
// Assertion macros for the spectral peak grain picker top level.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef SPECTRAL_PEAK_GRAIN_PICKER_TOP_ASSERT_SVH
`define SPECTRAL_PEAK_GRAIN_PICKER_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SPG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define SPG_ASSERT_NEXT(lbl, cond, expct, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) else $error(msg);

`endif

FILE: hdl/spg_pkg.sv
// Shared types and constants of the spectral peak grain picker.
// No dependencies; used by all modules of the block.
package spg_pkg;

    localparam int NUM_BINS   = 512;
    localparam int MAX_GRAINS = 20;

    localparam int AMP_W      = 24;
    localparam int FREQ_W     = 20;
    localparam int CFG_BIN_W  = 10;
    localparam int GCOUNT_W   = 5;
    localparam int PROB_W     = 17;
    localparam int SEED_W     = 16;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;

    localparam int BIN_IDX_W  = $clog2(NUM_BINS + 1);
    localparam int RANK_W     = $clog2(MAX_GRAINS + 1);
    localparam int IDX_CMP_W  = (BIN_IDX_W > CFG_BIN_W) ? BIN_IDX_W : CFG_BIN_W;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_BIN_W-1:0] LOWEST_RST  = 10'd0;
    localparam logic [CFG_BIN_W-1:0] HIGHEST_RST = 10'd24;
    localparam logic [GCOUNT_W-1:0]  GCOUNT_RST  = 5'd1;
    localparam logic [PROB_W-1:0]    PROB_RST    = 17'd7;
    localparam logic [SEED_W-1:0]    SEED_RST    = 16'd1;

    typedef enum logic [2:0] {
        REG_LOWEST  = 3'd0,
        REG_HIGHEST = 3'd1,
        REG_GCOUNT  = 3'd2,
        REG_PROB    = 3'd3,
        REG_SEED    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic              valid;
        logic [AMP_W-1:0]  amp;
        logic [FREQ_W-1:0] freq;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: hdl/spg_cell.sv
// One rank cell of the sorted candidate chain.
// Depends on spg_pkg for the entry and control types.
module spg_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spg_pkg::cell_ctrl_t ctrl,
    input  spg_pkg::entry_t     new_entry,
    input  spg_pkg::entry_t     upper_entry,
    input  logic                upper_beats,
    input  spg_pkg::entry_t     lower_entry,
    output spg_pkg::entry_t     entry,
    output logic                beats
);
    import spg_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [AMP_W-1:0]  amp_reg;
    logic [AMP_W-1:0]  amp_next;
    logic [FREQ_W-1:0] freq_reg;
    logic [FREQ_W-1:0] freq_next;

    // An equal amplitude stays ahead, so the earlier bin keeps the better rank.
    assign beats = !valid_reg || (amp_reg < new_entry.amp);

    always_comb
    begin
        valid_next = valid_reg;
        amp_next   = amp_reg;
        freq_next  = freq_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (beats && !upper_beats)
            begin
                valid_next = 1'b1;
                amp_next   = new_entry.amp;
                freq_next  = new_entry.freq;
            end
            else if (beats)
            begin
                valid_next = upper_entry.valid;
                amp_next   = upper_entry.amp;
                freq_next  = upper_entry.freq;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = lower_entry.valid;
            amp_next   = lower_entry.amp;
            freq_next  = lower_entry.freq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_reg  <= amp_next;
        freq_reg <= freq_next;
    end

    assign entry.valid = valid_reg;
    assign entry.amp   = amp_reg;
    assign entry.freq  = freq_reg;

endmodule

FILE: hdl/spg_gate.sv
// Random pass gate: 16-bit Galois LFSR compared against the probability.
// Depends on spg_pkg for widths, taps and the reset seed.
module spg_gate (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_load,
    input  logic [spg_pkg::SEED_W-1:0]  seed,
    input  logic                        advance,
    input  logic [spg_pkg::PROB_W-1:0]  prob,
    output logic                        pass
);
    import spg_pkg::*;

    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic [SEED_W-1:0] lfsr_adv;

    assign lfsr_adv = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    // The LFSR never exceeds 65535, so any probability of 65536 or more always passes.
    assign pass = ({1'b0, lfsr_adv} < prob);

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (seed_load)
        begin
            lfsr_next = (seed == '0) ? SEED_W'(1) : seed;
        end
        else if (advance)
        begin
            lfsr_next = lfsr_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_RST;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

FILE: hdl/spectral_peak_grain_picker_top.sv
// Top level of the spectral peak grain picker: APB registers, bin counter,
// chain of rank cells, drain control and output register.
// Depends on spg_pkg, spg_cell, spg_gate and the assertion macro header.
//
//  channel  | signals                                         | role
//  ---------+-------------------------------------------------+--------------------
//  bin      | bin_valid/bin_ready, amplitude, frequency, last | one spectral bin in
//  grain    | grain_valid/grain_ready, amplitude, freq, last  | selected grains out
//  apb      | psel penable pwrite paddr pwdata prdata pready  | register access
//
// The chain of rank cells sorts each bin in as it arrives.
// After the last bin of a frame the chain drains through the random gate, one
// valid rank per cycle while the grain side does not stall, up to k_lim ranks;
// no bin request is taken during the drain.
// The reset is asynchronous, clears the list and the bin counter, and loads the LFSR with its reset seed.
module spectral_peak_grain_picker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         bin_valid,
    output logic                         bin_ready,
    input  logic [spg_pkg::AMP_W-1:0]    bin_amplitude,
    input  logic [spg_pkg::FREQ_W-1:0]   bin_frequency,
    input  logic                         last_bin,
    output logic                         grain_valid,
    input  logic                         grain_ready,
    output logic [spg_pkg::AMP_W-1:0]    grain_amplitude,
    output logic [spg_pkg::FREQ_W-1:0]   grain_frequency,
    output logic                         last_grain,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spg_pkg::ADDR_W-1:0]   paddr,
    input  logic [spg_pkg::DATA_W-1:0]   pwdata,
    output logic [spg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import spg_pkg::*;

    `include "spectral_peak_grain_picker_top_assert.svh"

    typedef enum logic [2:0] {
        ST_COLLECT = 3'b001,
        ST_DRAIN   = 3'b010,
        ST_FLUSH   = 3'b100
    } state_t;

    // Configuration registers
    logic [CFG_BIN_W-1:0] lowest_reg;
    logic [CFG_BIN_W-1:0] highest_reg;
    logic [GCOUNT_W-1:0]  gcount_reg;
    logic [PROB_W-1:0]    prob_reg;
    logic [SEED_W-1:0]    seed_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_write;
    logic                 seed_load;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign seed_load = cfg_write && (reg_idx == REG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= LOWEST_RST;
            highest_reg <= HIGHEST_RST;
            gcount_reg  <= GCOUNT_RST;
            prob_reg    <= PROB_RST;
            seed_reg    <= SEED_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_LOWEST:  lowest_reg  <= pwdata[CFG_BIN_W-1:0];
                REG_HIGHEST: highest_reg <= pwdata[CFG_BIN_W-1:0];
                REG_GCOUNT:  gcount_reg  <= pwdata[GCOUNT_W-1:0];
                REG_PROB:    prob_reg    <= pwdata[PROB_W-1:0];
                REG_SEED:    seed_reg    <= pwdata[SEED_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LOWEST:  prdata = DATA_W'(lowest_reg);
            REG_HIGHEST: prdata = DATA_W'(highest_reg);
            REG_GCOUNT:  prdata = DATA_W'(gcount_reg);
            REG_PROB:    prdata = DATA_W'(prob_reg);
            REG_SEED:    prdata = DATA_W'(seed_reg);
            default:     prdata = '0;
        endcase
    end

    // Number of ranks offered to the gate.
    logic [GCOUNT_W-1:0]  gcount_fix;
    logic [CFG_BIN_W-1:0] gcount_cap;
    logic [CFG_BIN_W-1:0] span;
    logic [CFG_BIN_W-1:0] k_lim;

    always_comb
    begin
        gcount_fix = (gcount_reg == '0) ? GCOUNT_W'(1) : gcount_reg;
        gcount_cap = CFG_BIN_W'(gcount_fix);
        if (gcount_cap > CFG_BIN_W'(MAX_GRAINS))
        begin
            gcount_cap = CFG_BIN_W'(MAX_GRAINS);
        end
        span  = (highest_reg > lowest_reg) ? (highest_reg - lowest_reg) : '0;
        k_lim = (gcount_cap < span) ? gcount_cap : span;
    end

    // Control state
    state_t               state_reg;
    state_t               state_next;
    logic [BIN_IDX_W-1:0] bin_idx_reg;
    logic [BIN_IDX_W-1:0] bin_idx_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [AMP_W-1:0]     pend_amp_reg;
    logic [AMP_W-1:0]     pend_amp_next;
    logic [FREQ_W-1:0]    pend_freq_reg;
    logic [FREQ_W-1:0]    pend_freq_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [AMP_W-1:0]     out_amp_reg;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic                 out_last_reg;

    logic                 bin_accept;
    logic                 eligible;
    logic                 step;
    logic                 cand;
    logic                 gate_pass;
    logic                 gate_adv;
    logic                 emit;
    logic                 emit_last;
    cell_ctrl_t           cell_ctrl;

    entry_t               new_entry;
    entry_t               entry_w     [MAX_GRAINS];
    logic                 beats_w     [MAX_GRAINS];
    entry_t               upper_ent_w [MAX_GRAINS];
    logic                 upper_bt_w  [MAX_GRAINS];
    entry_t               lower_ent_w [MAX_GRAINS];
    logic [MAX_GRAINS-1:0] valid_vec;

    assign bin_ready  = (state_reg == ST_COLLECT);
    assign bin_accept = bin_valid && bin_ready;

    assign eligible = (IDX_CMP_W'(bin_idx_reg) < IDX_CMP_W'(NUM_BINS))
                   && (IDX_CMP_W'(bin_idx_reg) >= IDX_CMP_W'(lowest_reg))
                   && (IDX_CMP_W'(bin_idx_reg) < IDX_CMP_W'(highest_reg));

    // The drain moves only while the output register can take a grain.
    assign step = !out_valid_reg || grain_ready;
    assign cand = (CFG_BIN_W'(rank_reg) < k_lim) && entry_w[0].valid;

    assign new_entry.valid = 1'b1;
    assign new_entry.amp   = bin_amplitude;
    assign new_entry.freq  = bin_frequency;

    always_comb
    begin
        for (int i = 0; i < MAX_GRAINS; i++)
        begin
            valid_vec[i] = entry_w[i].valid;
            if (i == 0)
            begin
                upper_ent_w[i] = new_entry;
                upper_bt_w[i]  = 1'b0;
            end
            else
            begin
                upper_ent_w[i] = entry_w[i-1];
                upper_bt_w[i]  = beats_w[i-1];
            end
            if (i == MAX_GRAINS - 1)
            begin
                lower_ent_w[i] = '0;
            end
            else
            begin
                lower_ent_w[i] = entry_w[i+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_GRAINS; g++)
    begin : g_cell
        spg_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .new_entry   (new_entry),
            .upper_entry (upper_ent_w[g]),
            .upper_beats (upper_bt_w[g]),
            .lower_entry (lower_ent_w[g]),
            .entry       (entry_w[g]),
            .beats       (beats_w[g])
        );
    end

    spg_gate u_gate (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_load (seed_load),
        .seed      (pwdata[SEED_W-1:0]),
        .advance   (gate_adv),
        .prob      (prob_reg),
        .pass      (gate_pass)
    );

    always_comb
    begin
        state_next      = state_reg;
        bin_idx_next    = bin_idx_reg;
        rank_next       = rank_reg;
        pend_valid_next = pend_valid_reg;
        pend_amp_next   = pend_amp_reg;
        pend_freq_next  = pend_freq_reg;
        cell_ctrl       = '0;
        gate_adv        = 1'b0;
        emit            = 1'b0;
        emit_last       = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                if (bin_accept)
                begin
                    cell_ctrl.insert = eligible;
                    if (bin_idx_reg != BIN_IDX_W'(NUM_BINS))
                    begin
                        bin_idx_next = bin_idx_reg + BIN_IDX_W'(1);
                    end
                    if (last_bin)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (step)
                begin
                    if (!cand)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        gate_adv        = 1'b1;
                        cell_ctrl.shift = 1'b1;
                        rank_next       = rank_reg + RANK_W'(1);
                        // A passing grain waits until the next one is known,
                        // so the final grain of the frame can be marked.
                        if (gate_pass)
                        begin
                            emit            = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_amp_next   = entry_w[0].amp;
                            pend_freq_next  = entry_w[0].freq;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (step)
                begin
                    emit            = pend_valid_reg;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    cell_ctrl.clear = 1'b1;
                    bin_idx_next    = '0;
                    rank_next       = '0;
                    state_next      = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (grain_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            bin_idx_reg    <= '0;
            rank_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bin_idx_reg    <= bin_idx_next;
            rank_reg       <= rank_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_amp_reg  <= pend_amp_next;
        pend_freq_reg <= pend_freq_next;
        if (emit)
        begin
            out_amp_reg  <= pend_amp_reg;
            out_freq_reg <= pend_freq_reg;
            out_last_reg <= emit_last;
        end
    end

    assign grain_valid     = out_valid_reg;
    assign grain_amplitude = out_amp_reg;
    assign grain_frequency = out_freq_reg;
    assign last_grain      = out_last_reg;

    // Valid entries always form an unbroken run from the top rank down.
    `SPG_ASSERT_ALWAYS(a_valid_prefix, ((valid_vec & (valid_vec + MAX_GRAINS'(1))) == '0), "rank list has a gap")
    // No grain is held back while new bins are being collected.
    `SPG_ASSERT_ALWAYS(a_no_pend_collect, (state_reg == ST_COLLECT) |-> !pend_valid_reg, "pending grain during collect")
    // A new grain only appears as a result of the drain.
    `SPG_ASSERT_ALWAYS(a_grain_from_drain, $rose(grain_valid) |-> $past(state_reg != ST_COLLECT), "grain outside drain")
    // Finishing a frame leaves the list empty and the bin counter at zero.
    `SPG_ASSERT_NEXT(a_flush_clears, (state_reg == ST_FLUSH) && step, (valid_vec == '0) && (bin_idx_reg == '0) && (state_reg == ST_COLLECT), "frame end did not clear")

endmodule
